// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned KIND_BITS = 3;
  localparam int unsigned OCC_BITS  = 5;

  localparam logic [KIND_BITS-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_POP_REAR   = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_NONE       = 3'd4;

  typedef struct packed {
    logic [KIND_BITS-1:0]        kind;
    logic signed [DATA_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] front_value;
    logic signed [DATA_BITS-1:0] rear_value;
    logic                        is_empty;
    logic                        is_full;
    logic [OCC_BITS-1:0]         occupancy;
    logic                        error;
  } out_t;

  // step commands from the controller to the datapath, at most one high at a time
  typedef struct packed {
    logic load;
    logic exec;
    logic rd;
  } cmd_t;

endpackage

// ===== hw/rtl/deq_ctrl.sv =====
module deq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_stall_i,
  output deq_pkg::cmd_t cmd_o,
  output logic          in_stall_o,
  output logic          out_valid_o
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_RESP
  } state_e;

  state_e state_q;
  logic   exec_q;
  logic   rd_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      exec_q      <= 1'b0;
      rd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      exec_q <= 1'b0;
      rd_q   <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
            exec_q  <= 1'b1;
          end
        end
        ST_EXEC: begin
          state_q <= ST_READ;
          rd_q    <= 1'b1;
        end
        ST_READ: begin
          state_q     <= ST_RESP;
          out_valid_q <= 1'b1;
        end
        ST_RESP: begin
          if (!out_stall_i) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.exec  = exec_q;
  assign cmd_o.rd    = rd_q;

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.exec, cmd_o.rd}))
    else $error("controller issued more than one step command");
  a_exec_then_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> cmd_o.rd)
    else $error("update was not followed by a store read");
  a_read_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> out_valid_o)
    else $error("store read was not followed by a result");
  a_busy_while_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");
`endif

endmodule

// ===== hw/rtl/deq_dp.sv =====
module deq_dp #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  deq_pkg::cmd_t cmd_i,
  input  deq_pkg::in_t  in_data_i,
  output deq_pkg::out_t out_data_o
);
  import deq_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [63:0]      ONES     = '1;
  localparam logic [63:0]      EMPTY_WORD = ONES >> (64 - WORD_BITS);

  // circular add of two indexes below CAPACITY
  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (IDX_W+1)'(CAPACITY)) begin
      sum = sum - (IDX_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [DATA_BITS-1:0] fit_word(logic [WORD_BITS-1:0] w);
    logic [63:0] ext;
    ext = 64'(w);
    return ext[DATA_BITS-1:0];
  endfunction

  logic [WORD_BITS-1:0] mem_q [CAPACITY];

  logic [KIND_BITS-1:0] kind_q;
  logic [WORD_BITS-1:0] word_q;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 err_q, err_d;
  logic [WORD_BITS-1:0] front_rd_q, rear_rd_q;

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [IDX_W-1:0]     head_dec, head_inc, tail_addr, rear_addr;
  logic                 full, empty;
  logic [63:0]          value_ext;
  logic [31:0]          cnt_ext;

  assign full      = (cnt_q == CNT_CAP);
  assign empty     = (cnt_q == '0);
  assign head_dec  = (head_q == '0) ? IDX_LAST : head_q - IDX_W'(1);
  assign head_inc  = wrap_add(head_q, IDX_W'(1));
  assign tail_addr = wrap_add(head_q, cnt_q[IDX_W-1:0]);
  assign rear_addr = wrap_add(head_q, cnt_q[IDX_W-1:0] - IDX_W'(1));
  assign value_ext = {{32{in_data_i.value[DATA_BITS-1]}}, in_data_i.value};

  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    err_d  = 1'b0;
    we     = 1'b0;
    waddr  = tail_addr;
    case (kind_q)
      KIND_PUSH_FRONT: begin
        if (full) begin
          err_d = 1'b1;
        end else begin
          head_d = head_dec;
          waddr  = head_dec;
          we     = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
      end
      KIND_PUSH_REAR: begin
        if (full) begin
          err_d = 1'b1;
        end else begin
          we    = 1'b1;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          err_d = 1'b1;
        end else begin
          head_d = head_inc;
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      KIND_POP_REAR: begin
        if (empty) begin
          err_d = 1'b1;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      default: begin
        err_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
      err_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      err_q  <= err_d;
    end
  end

  // latch the item; unknown kinds fall through as no change
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_data_i.kind;
      word_q <= value_ext[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem_q[waddr] <= word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      front_rd_q <= mem_q[head_q];
      rear_rd_q  <= mem_q[rear_addr];
    end
  end

  assign cnt_ext = 32'(cnt_q);

  always_comb begin
    out_data_o.front_value = empty ? EMPTY_WORD[DATA_BITS-1:0] : fit_word(front_rd_q);
    out_data_o.rear_value  = empty ? EMPTY_WORD[DATA_BITS-1:0] : fit_word(rear_rd_q);
    out_data_o.is_empty    = empty;
    out_data_o.is_full     = full;
    out_data_o.occupancy   = cnt_ext[OCC_BITS-1:0];
    out_data_o.error       = err_q;
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_CAP)
    else $error("count exceeds capacity");
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= IDX_LAST)
    else $error("head index out of range");
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(cnt_q) && $stable(head_q))
    else $error("pointers moved outside an update");
  a_err_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && err_d |=> $stable(cnt_q) && $stable(head_q))
    else $error("faulted operation changed the queue");
`endif

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// Channel  Direction  Handshake           Payload
// in       input      in_valid_i/_stall_o  deq_pkg::in_t  (kind, value)
// out      output     out_valid_o/_stall_i deq_pkg::out_t (front, rear, flags, count, error)
//
// An item goes through these steps in order: latch, update and
// store write, two-port store read into registers, result. The store's single
// write port and registered read set that sequence; one item is in flight.
// Reset clears head and count; store contents stay undefined until written.
// in_stall_o is high from acceptance until the result is taken; a stalled
// result holds its value.
module double_ended_queue #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  deq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output deq_pkg::out_t out_data_o
);
  import deq_pkg::*;

  cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  deq_dp #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
